@@ sv/mlfq_pkg.sv @@
// Package for the multilevel feedback scheduler: constants, codes and types.
package mlfq_pkg;

  localparam int MaxProcs  = 16;
  localparam int NumLevels = 10;
  localparam int PidBits   = 16;

  localparam int ReqW = 3;
  localparam int StW  = 3;
  localparam int PrW  = 4;
  localparam int VaW  = 16;
  localparam int RecW = 16;

  localparam logic [ReqW-1:0] REQ_CREATE  = 3'd0;
  localparam logic [ReqW-1:0] REQ_TICK    = 3'd1;
  localparam logic [ReqW-1:0] REQ_BLOCK   = 3'd2;
  localparam logic [ReqW-1:0] REQ_UNBLOCK = 3'd3;
  localparam logic [ReqW-1:0] REQ_KILL    = 3'd4;
  localparam logic [ReqW-1:0] REQ_NICE    = 3'd5;
  localparam logic [ReqW-1:0] REQ_WAIT    = 3'd6;
  localparam logic [ReqW-1:0] REQ_UNUSED  = 3'd7;

  localparam logic [StW-1:0] STAT_OK       = 3'd0;
  localparam logic [StW-1:0] STAT_NOTFOUND = 3'd1;
  localparam logic [StW-1:0] STAT_ILLEGAL  = 3'd2;
  localparam logic [StW-1:0] STAT_BADPRIO  = 3'd3;
  localparam logic [StW-1:0] STAT_FULL     = 3'd4;

  localparam logic [1:0] RS_READY   = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_BLOCKED = 2'd2;
  localparam logic [1:0] RS_EXITED  = 2'd3;

endpackage

@@ sv/mlfq_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface mlfq_req_if;
  logic                      valid;
  logic                      ready;
  logic [mlfq_pkg::ReqW-1:0] req_type;
  logic [15:0]               target_pid;
  logic [mlfq_pkg::PrW-1:0]  new_priority;
  modport source (output valid, req_type, target_pid, new_priority, input ready);
  modport sink (input valid, req_type, target_pid, new_priority, output ready);
endinterface

interface mlfq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [mlfq_pkg::StW-1:0]  status;
  logic [15:0]               result_value;
  logic [15:0]               running_pid;
  logic                      cpu_idle;
  modport source (output valid, status, result_value, running_pid, cpu_idle, input ready);
  modport sink (input valid, status, result_value, running_pid, cpu_idle, output ready);
endinterface

@@ sv/multilevel_feedback_process_scheduler.sv @@
// Top level of the multilevel feedback process scheduler.
// An unknown request is answered without a sweep; the others wait on sweeps that read
// the entry memory one slot per cycle, with a further sweep when a tick or kill retires
// an entry.
// One request is worked at a time; the next is taken once the response has been accepted.
// Reset (synchronous, rst high) clears valid bits, the current slot and the recency
// counter, sets the idle flag, starts pids at 1; entry payload memory is not cleared.
module multilevel_feedback_process_scheduler #(
  parameter int MAX_PROCS  = mlfq_pkg::MaxProcs,
  parameter int NUM_LEVELS = mlfq_pkg::NumLevels,
  parameter int PID_BITS   = mlfq_pkg::PidBits
) (
  input logic       clk,
  input logic       rst,
  mlfq_req_if.sink  req,
  mlfq_rsp_if.source rsp
);
  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int LW = mlfq_pkg::PrW;
  localparam int RW = mlfq_pkg::RecW;

  // Phases of the sequencer.
  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SCAN = 3'd1;  // lookup / free slot sweep
  localparam logic [2:0] P_RET  = 3'd2;  // retire: ready waiters
  localparam logic [2:0] P_CUR  = 3'd3;  // tick, wait, kill: read current entry
  localparam logic [2:0] P_PICK = 3'd4;  // tick: select ready entry
  localparam logic [2:0] P_DONE = 3'd5;

  typedef struct packed {
    logic [PID_BITS-1:0] pid;
    logic [LW-1:0]       level;
    logic [1:0]          rs;
    logic [RW-1:0]       rec;
    logic [PID_BITS-1:0] wpid;
  } entry_t;

  function automatic entry_t ent(logic [PID_BITS-1:0] pid, logic [LW-1:0] level,
                                 logic [1:0] rs, logic [RW-1:0] rec,
                                 logic [PID_BITS-1:0] wpid);
    entry_t e;
    e.pid = pid;
    e.level = level;
    e.rs = rs;
    e.rec = rec;
    e.wpid = wpid;
    return e;
  endfunction

  // Entry memory with registered read; valid and wait-valid bits in flops.
  // The sequencer writes it directly; a read issued at the write edge sees the old entry.
  entry_t mem [MAX_PROCS];
  logic [SW-1:0] raddr;
  entry_t rdata;
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  logic [MAX_PROCS-1:0] ev, wv;
  logic [2:0]  ph;
  logic [CW-1:0] cnt;      // slot being read this cycle
  logic        rd_ok;      // rdata valid for slot cnt-1
  logic [SW-1:0] rslot;
  logic [mlfq_pkg::ReqW-1:0] rq;
  logic [PID_BITS-1:0] tp;
  logic [LW-1:0] pr;
  logic [SW-1:0] cur;
  logic        idle;
  logic [PID_BITS-1:0] npid;
  logic [RW-1:0] rc;
  logic        found;
  logic [SW-1:0] fslot;
  entry_t      fent;
  logic [PID_BITS-1:0] retpid;
  logic        bfound;
  logic [SW-1:0] bslot;
  logic [LW-1:0] blev;
  logic [RW-1:0] bage;
  logic [mlfq_pkg::StW-1:0] ostat;
  logic [15:0] oval;

  logic    live;
  logic [RW-1:0] age;
  assign live = !idle && ev[cur];
  assign rslot = cnt[SW-1:0] - SW'(1);
  assign age = rc - rdata.rec;
  assign req.ready = (ph == P_IDLE) && !rsp.valid;

  always_comb begin
    raddr = cnt[SW-1:0];
    if (cnt >= CW'(MAX_PROCS)) raddr = '0;
    if (ph inside {P_IDLE, P_CUR, P_DONE}) raddr = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= '0; wv <= '0; ph <= P_IDLE; cur <= '0; idle <= 1'b1;
      npid <= PID_BITS'(1); rc <= '0; rsp.valid <= 1'b0; cnt <= '0; rd_ok <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (ph)
        P_IDLE: begin
          if (req.valid && req.ready) begin
            rq <= req.req_type; tp <= PID_BITS'(req.target_pid); pr <= req.new_priority;
            ostat <= mlfq_pkg::STAT_OK; oval <= '0;
            found <= 1'b0; bfound <= 1'b0; cnt <= '0; rd_ok <= 1'b0;
            case (req.req_type)
              mlfq_pkg::REQ_TICK: begin
                ph <= live ? P_CUR : P_PICK;
              end
              mlfq_pkg::REQ_CREATE, mlfq_pkg::REQ_BLOCK, mlfq_pkg::REQ_UNBLOCK,
              mlfq_pkg::REQ_KILL, mlfq_pkg::REQ_NICE, mlfq_pkg::REQ_WAIT:
                ph <= P_SCAN;
              default: ph <= P_DONE;
            endcase
          end
        end
        P_SCAN: begin
          // Sweep reads; on each returned entry check for the lowest match.
          if (cnt < CW'(MAX_PROCS)) cnt <= cnt + CW'(1);
          rd_ok <= (cnt < CW'(MAX_PROCS));
          if (rd_ok && !found) begin
            if (rq == mlfq_pkg::REQ_CREATE) begin
              if (!ev[rslot]) begin found <= 1'b1; fslot <= rslot; end
            end else if (ev[rslot] && rdata.pid == tp) begin
              found <= 1'b1; fslot <= rslot; fent <= rdata;
            end
          end
          if (!rd_ok && cnt == CW'(MAX_PROCS)) begin
            ph <= P_DONE;
            case (rq)
              mlfq_pkg::REQ_CREATE: begin
                if (!found) ostat <= mlfq_pkg::STAT_FULL;
                else begin
                  ev[fslot] <= 1'b1; wv[fslot] <= 1'b0;
                  mem[fslot] <= ent(npid, '0, mlfq_pkg::RS_READY, rc + RW'(1), '0);
                  rc <= rc + RW'(1);
                  oval <= 16'(npid);
                  npid <= (npid + PID_BITS'(1) == '0) ? PID_BITS'(1) : npid + PID_BITS'(1);
                end
              end
              mlfq_pkg::REQ_BLOCK, mlfq_pkg::REQ_UNBLOCK: begin
                if (!found || fent.rs == mlfq_pkg::RS_EXITED) ostat <= mlfq_pkg::STAT_NOTFOUND;
                else if (rq == mlfq_pkg::REQ_BLOCK && fent.rs == mlfq_pkg::RS_BLOCKED)
                  ostat <= mlfq_pkg::STAT_ILLEGAL;
                else
                  mem[fslot] <= ent(fent.pid, fent.level,
                                    (rq == mlfq_pkg::REQ_BLOCK) ? mlfq_pkg::RS_BLOCKED
                                                                : mlfq_pkg::RS_READY,
                                    fent.rec, fent.wpid);
              end
              mlfq_pkg::REQ_NICE: begin
                if (!found) ostat <= mlfq_pkg::STAT_NOTFOUND;
                else if (32'(pr) >= 32'(NUM_LEVELS)) ostat <= mlfq_pkg::STAT_BADPRIO;
                else begin
                  mem[fslot] <= ent(fent.pid, pr, fent.rs, rc + RW'(1), fent.wpid);
                  rc <= rc + RW'(1); oval <= 16'(pr);
                end
              end
              mlfq_pkg::REQ_WAIT: begin
                if (!live) ostat <= mlfq_pkg::STAT_ILLEGAL;
                else if (!found) ostat <= mlfq_pkg::STAT_NOTFOUND;
                else ph <= P_CUR;  // needs the current entry
              end
              mlfq_pkg::REQ_KILL: begin
                if (live && found && fslot == cur) ph <= P_CUR;
                else if (live) ph <= P_CUR;  // current pid may match a lower dup? check there
                else if (!found) ostat <= mlfq_pkg::STAT_NOTFOUND;
                else begin
                  ev[fslot] <= 1'b0; wv[fslot] <= 1'b0; retpid <= fent.pid;
                  cnt <= '0; ph <= P_RET;
                end
              end
              default: ;
            endcase
          end
        end
        P_CUR: begin
          // First issue the read of cur, then use the returned entry.
          if (!rd_ok) begin
            cnt <= CW'(cur); rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0; cnt <= '0;
            if (rq == mlfq_pkg::REQ_WAIT) begin
              ph <= P_DONE;
              if (rdata.rs == mlfq_pkg::RS_BLOCKED || rdata.rs == mlfq_pkg::RS_EXITED)
                ostat <= mlfq_pkg::STAT_ILLEGAL;
              else begin
                wv[cur] <= 1'b1;
                mem[cur] <= ent(rdata.pid, rdata.level, mlfq_pkg::RS_BLOCKED, rdata.rec, tp);
              end
            end else if (rq == mlfq_pkg::REQ_KILL) begin
              if (rdata.pid == tp) begin
                ph <= P_DONE;
                mem[cur] <= ent(rdata.pid, rdata.level, mlfq_pkg::RS_EXITED, rdata.rec,
                                rdata.wpid);
              end else if (!found) begin
                ph <= P_DONE; ostat <= mlfq_pkg::STAT_NOTFOUND;
              end else begin
                ev[fslot] <= 1'b0; wv[fslot] <= 1'b0; retpid <= fent.pid; ph <= P_RET;
              end
            end else begin
              ph <= P_PICK;
              case (rdata.rs)
                mlfq_pkg::RS_EXITED: begin
                  ev[cur] <= 1'b0; wv[cur] <= 1'b0; retpid <= rdata.pid; ph <= P_RET;
                end
                mlfq_pkg::RS_RUNNING: begin
                  if (32'(rdata.level) + 1 < NUM_LEVELS) begin
                    mem[cur] <= ent(rdata.pid, rdata.level + LW'(1), mlfq_pkg::RS_READY,
                                    rc + RW'(1), rdata.wpid);
                    rc <= rc + RW'(1);
                  end else begin
                    mem[cur] <= ent(rdata.pid, rdata.level, mlfq_pkg::RS_READY, rdata.rec,
                                    rdata.wpid);
                  end
                end
                mlfq_pkg::RS_BLOCKED: begin
                  if (rdata.level != '0) begin
                    mem[cur] <= ent(rdata.pid, rdata.level - LW'(1), rdata.rs, rc + RW'(1),
                                    rdata.wpid);
                    rc <= rc + RW'(1);
                  end
                end
                default: ;
              endcase
            end
          end
        end
        P_RET: begin
          // Sweep: waiters of retpid lose their wait and become ready.
          // Each write lands while the next slot is being read.
          if (cnt < CW'(MAX_PROCS)) cnt <= cnt + CW'(1);
          rd_ok <= (cnt < CW'(MAX_PROCS));
          if (rd_ok && ev[rslot] && wv[rslot] && rdata.wpid == retpid) begin
            wv[rslot] <= 1'b0;
            if (rdata.rs != mlfq_pkg::RS_EXITED)
              mem[rslot] <= ent(rdata.pid, rdata.level, mlfq_pkg::RS_READY, rdata.rec,
                                rdata.wpid);
          end
          if (!rd_ok && cnt == CW'(MAX_PROCS)) begin
            cnt <= '0;
            ph <= (rq == mlfq_pkg::REQ_TICK) ? P_PICK : P_DONE;
          end
        end
        P_PICK: begin
          if (cnt < CW'(MAX_PROCS)) cnt <= cnt + CW'(1);
          rd_ok <= (cnt < CW'(MAX_PROCS));
          if (rd_ok && ev[rslot] && rdata.rs == mlfq_pkg::RS_READY &&
              (!bfound || rdata.level < blev || (rdata.level == blev && age < bage))) begin
            bfound <= 1'b1; bslot <= rslot; blev <= rdata.level; bage <= age;
            fent <= rdata;
          end
          if (!rd_ok && cnt == CW'(MAX_PROCS)) begin
            ph <= P_DONE;
            if (bfound) begin
              cur <= bslot; idle <= 1'b0;
              mem[bslot] <= ent(fent.pid, fent.level, mlfq_pkg::RS_RUNNING, fent.rec,
                                fent.wpid);
            end else idle <= 1'b1;
          end
        end
        P_DONE: begin
          // Read the current entry, then answer with it.
          if (!rd_ok) begin
            rd_ok <= 1'b1; cnt <= CW'(cur);
          end else begin
            rd_ok <= 1'b0; cnt <= '0;
            rsp.valid <= 1'b1;
            rsp.status <= ostat;
            rsp.result_value <= oval;
            rsp.cpu_idle <= !live;
            rsp.running_pid <= live ? 16'(rdata.pid) : 16'd0;
            ph <= P_IDLE;
          end
        end
        default: ph <= P_IDLE;
      endcase
    end
  end
endmodule
